### rtl/core/sha_pkg.sv
// Shared types, constants and round functions for the SHA-512 hash engine.
// No dependencies; used by every module in rtl/core.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

   localparam int unsigned BLOCK_BYTES = 128;
   localparam int unsigned LEN_START = 112;
   localparam int unsigned ROUNDS = 80;

   localparam logic [63:0] INIT_HASH [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
      64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
      64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   localparam logic [63:0] K_TABLE [80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   typedef struct packed {
      logic [63:0] data;
      logic [3:0]  cnt;
      logic        last;
   } item_type;

   typedef struct packed {
      logic [7:0] fill;
      logic [6:0] rnd;
      logic       in_round;
   } core_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FEED,
      ST_ROUND,
      ST_FINAL,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      PAD_MARK,
      PAD_ZERO,
      PAD_LEN_HI,
      PAD_LEN_LO,
      PAD_DONE
   } pad_type;

   function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned amt);
      return (x >> amt) | (x << (64 - amt));
   endfunction

endpackage
`default_nettype wire

### rtl/core/sha_front.sv
// Input side: takes request beats, saturates the byte count, drops empty non-final beats.
// Depends on sha_pkg; feeds sha_queue.
`timescale 1ns / 1ps
`default_nettype none
module sha_front (
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [63:0]      req_data_word,
   input  wire logic [3:0]       req_byte_count,
   input  wire logic             req_last,
   input  wire logic             q_full,
   output logic                  q_push,
   output sha_pkg::item_type     q_item
);

   always_comb begin
      req_stall = q_full;
      q_item.data = req_data_word;
      q_item.cnt = (req_byte_count > 4'd8) ? 4'd8 : req_byte_count;
      q_item.last = req_last;
      q_push = req_valid && !q_full && (req_last || (req_byte_count != 4'd0));
   end

endmodule
`default_nettype wire

### rtl/core/sha_queue.sv
// Two-entry queue between the front and the compression core.
// Depends on sha_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none
module sha_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire sha_pkg::item_type push_item,
   input  wire logic              pop,
   output logic                   full,
   output logic                   not_empty,
   output sha_pkg::item_type      head,
   output logic [1:0]             level
);

   sha_pkg::item_type mem_ff [2];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;

   always_comb begin
      full = (count_ff == 2'd2);
      not_empty = (count_ff != 2'd0);
      head = mem_ff[rd_ptr_ff];
      level = count_ff;
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/sha_core.sv
// Back end: packs bytes into the block, pads, runs 80 rounds per block, returns the digest.
// Depends on sha_pkg; takes items from sha_queue.
`timescale 1ns / 1ps
`default_nettype none
module sha_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire sha_pkg::item_type q_item,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [63:0]            rsp_digest_word,
   output logic [2:0]             rsp_word_index,
   output logic                   rsp_last_word,
   output sha_pkg::core_stat_type stat
);

   sha_pkg::state_type state_ff, state_in;
   sha_pkg::pad_type   pad_ff, pad_in;
   logic [1023:0]      blk_ff, blk_in;
   logic [63:0]        hash_ff [8];
   logic [63:0]        hash_in [8];
   logic [63:0]        vars_ff [8];
   logic [63:0]        vars_in [8];
   logic [63:0]        total_ff, total_in;
   logic [7:0]         fill_ff, fill_in;
   logic [6:0]         rnd_ff, rnd_in;
   logic [2:0]         idx_ff, idx_in;
   logic [63:0]        dat_ff, dat_in;
   logic [3:0]         rem_ff, rem_in;
   logic               last_ff, last_in;

   logic [3:0]         n;
   logic [63:0]        ins;
   logic [1023:0]      shifted;
   logic [7:0]         space;
   logic [7:0]         gap;
   logic [63:0]        w0, w1, w9, w14, wnew, s1, t1, s0, t2;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha_pkg::ST_IDLE: begin
            if (q_valid) state_in = sha_pkg::ST_FEED;
         end
         sha_pkg::ST_FEED: begin
            if (fill_ff == 8'(sha_pkg::BLOCK_BYTES)) state_in = sha_pkg::ST_ROUND;
            else if (rem_ff != 4'd0) state_in = sha_pkg::ST_FEED;
            else if (!last_ff) state_in = sha_pkg::ST_IDLE;
            else if (pad_ff == sha_pkg::PAD_DONE) state_in = sha_pkg::ST_OUT;
         end
         sha_pkg::ST_ROUND: begin
            if (rnd_ff == 7'(sha_pkg::ROUNDS - 1)) state_in = sha_pkg::ST_FINAL;
         end
         sha_pkg::ST_FINAL: state_in = sha_pkg::ST_FEED;
         sha_pkg::ST_OUT: begin
            if (!rsp_stall && idx_ff == 3'd7) state_in = sha_pkg::ST_IDLE;
         end
         default: state_in = sha_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop = (state_ff == sha_pkg::ST_IDLE) && q_valid;
      rsp_valid = (state_ff == sha_pkg::ST_OUT);
      rsp_digest_word = hash_ff[idx_ff];
      rsp_word_index = idx_ff;
      rsp_last_word = (idx_ff == 3'd7);
      stat.fill = fill_ff;
      stat.rnd = rnd_ff;
      stat.in_round = (state_ff == sha_pkg::ST_ROUND);
   end

   always_comb begin
      w0 = blk_ff[1023:960];
      w1 = blk_ff[959:896];
      w9 = blk_ff[447:384];
      w14 = blk_ff[127:64];
      wnew = (sha_pkg::rotr(w14, 19) ^ sha_pkg::rotr(w14, 61) ^ (w14 >> 6)) + w9
           + (sha_pkg::rotr(w1, 1) ^ sha_pkg::rotr(w1, 8) ^ (w1 >> 7)) + w0;
      s1 = sha_pkg::rotr(vars_ff[4], 14) ^ sha_pkg::rotr(vars_ff[4], 18)
         ^ sha_pkg::rotr(vars_ff[4], 41);
      t1 = vars_ff[7] + s1 + ((vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]))
         + sha_pkg::K_TABLE[rnd_ff] + w0;
      s0 = sha_pkg::rotr(vars_ff[0], 28) ^ sha_pkg::rotr(vars_ff[0], 34)
         ^ sha_pkg::rotr(vars_ff[0], 39);
      t2 = s0 + ((vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
         ^ (vars_ff[1] & vars_ff[2]));
   end

   always_comb begin
      pad_in = pad_ff;
      blk_in = blk_ff;
      hash_in = hash_ff;
      vars_in = vars_ff;
      total_in = total_ff;
      fill_in = fill_ff;
      rnd_in = rnd_ff;
      idx_in = idx_ff;
      dat_in = dat_ff;
      rem_in = rem_ff;
      last_in = last_ff;
      n = 4'd0;
      ins = dat_ff;
      space = 8'(sha_pkg::BLOCK_BYTES) - fill_ff;
      gap = ((fill_ff > 8'(sha_pkg::LEN_START)) ? 8'(sha_pkg::BLOCK_BYTES)
                                                 : 8'(sha_pkg::LEN_START)) - fill_ff;
      case (state_ff)
         sha_pkg::ST_IDLE: begin
            if (q_valid) begin
               dat_in = q_item.data;
               rem_in = q_item.cnt;
               last_in = q_item.last;
               pad_in = sha_pkg::PAD_MARK;
            end
         end
         sha_pkg::ST_FEED: begin
            if (fill_ff == 8'(sha_pkg::BLOCK_BYTES)) begin
               vars_in = hash_ff;
               rnd_in = 7'd0;
            end else if (rem_ff != 4'd0) begin
               n = ({4'd0, rem_ff} < space) ? rem_ff : space[3:0];
               dat_in = dat_ff << {n, 3'b000};
               rem_in = rem_ff - n;
               total_in = total_ff + 64'(n);
            end else if (last_ff) begin
               case (pad_ff)
                  sha_pkg::PAD_MARK: begin
                     n = 4'd1;
                     ins = 64'h8000_0000_0000_0000;
                     pad_in = sha_pkg::PAD_ZERO;
                  end
                  sha_pkg::PAD_ZERO: begin
                     ins = 64'd0;
                     if (fill_ff == 8'(sha_pkg::LEN_START)) pad_in = sha_pkg::PAD_LEN_HI;
                     else n = (gap > 8'd8) ? 4'd8 : gap[3:0];
                  end
                  sha_pkg::PAD_LEN_HI: begin
                     n = 4'd8;
                     ins = 64'd0;
                     pad_in = sha_pkg::PAD_LEN_LO;
                  end
                  sha_pkg::PAD_LEN_LO: begin
                     n = 4'd8;
                     ins = total_ff << 3;
                     pad_in = sha_pkg::PAD_DONE;
                  end
                  default: ;
               endcase
            end
         end
         sha_pkg::ST_ROUND: begin
            vars_in[7] = vars_ff[6];
            vars_in[6] = vars_ff[5];
            vars_in[5] = vars_ff[4];
            vars_in[4] = vars_ff[3] + t1;
            vars_in[3] = vars_ff[2];
            vars_in[2] = vars_ff[1];
            vars_in[1] = vars_ff[0];
            vars_in[0] = t1 + t2;
            blk_in = {blk_ff[959:0], wnew};
            rnd_in = rnd_ff + 7'd1;
         end
         sha_pkg::ST_FINAL: begin
            for (int j = 0; j < 8; j++) hash_in[j] = hash_ff[j] + vars_ff[j];
            fill_in = 8'd0;
         end
         sha_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  hash_in = sha_pkg::INIT_HASH;
                  total_in = 64'd0;
               end
            end
         end
         default: ;
      endcase
      shifted = blk_ff;
      for (int k = 1; k <= 8; k++) begin
         if (n == 4'(k)) shifted = (blk_ff << (8 * k)) | {960'd0, ins >> (64 - 8 * k)};
      end
      if (n != 4'd0) begin
         blk_in = shifted;
         fill_in = fill_ff + {4'd0, n};
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      vars_ff <= vars_in;
      dat_ff <= dat_in;
      rem_ff <= rem_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha_pkg::ST_IDLE;
         pad_ff <= sha_pkg::PAD_MARK;
         hash_ff <= sha_pkg::INIT_HASH;
         total_ff <= 64'd0;
         fill_ff <= 8'd0;
         rnd_ff <= 7'd0;
         idx_ff <= 3'd0;
      end else begin
         state_ff <= state_in;
         pad_ff <= pad_in;
         hash_ff <= hash_in;
         total_ff <= total_in;
         fill_ff <= fill_in;
         rnd_ff <= rnd_in;
         idx_ff <= idx_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/sha512_hash_engine.sv
// SHA-512 hash engine top level: front classifier, two-beat queue, compression core.
// Depends on sha_pkg, sha_front, sha_queue and sha_core.
//
// Request channel: one beat carries a big-endian 64-bit word, a byte count (0..8, counts
// above 8 saturate) and a last flag. Beats that carry no bytes and are not last are dropped.
// Response channel: eight beats per message, digest word H0 first, word index 0..7,
// last_word set on the eighth beat.
// Per beat: the core pops, packs and returns to idle, and takes the next beat only from idle;
// a beat that crosses a block boundary packs again after the block. Each full 1024-bit
// block adds a load, 80 rounds and a hash update in the single round unit.
// After the last beat: its pop and pack, the padding steps (marker, zero fill, length high
// and low words), the blocks that its bytes and the padding complete (one or two after the
// bytes), a move to the response state, then the eight response beats.
// The two-entry queue keeps taking beats while the core compresses or while the response
// side stalls; req_stall rises only when the queue is full.
// A stalled response beat holds; the core waits on it and resumes after acceptance.
// Reset: synchronous, active high; loads the initial hash value and empties the queue.
`timescale 1ns / 1ps
`default_nettype none
module sha512_hash_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_data_word,
   input  wire logic [3:0]  req_byte_count,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);

   sha_pkg::item_type      push_item;
   sha_pkg::item_type      head;
   sha_pkg::core_stat_type stat;
   logic                   q_full;
   logic                   q_push;
   logic                   q_pop;
   logic                   q_not_empty;
   logic [1:0]             q_level;

   sha_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last       (req_last),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_item         (push_item)
   );

   sha_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head),
      .level     (q_level)
   );

   sha_core u_core (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_not_empty),
      .q_item          (head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word),
      .stat            (stat)
   );

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      stat.fill <= 8'd128)
      else $error("block fill beyond 128 bytes");

   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      stat.in_round |-> stat.rnd < 7'd80)
      else $error("round index out of range");

   a_queue_level: assert property (@(posedge clock) disable iff (reset)
      q_level <= 2'd2 && (q_full == (q_level == 2'd2)))
      else $error("queue level inconsistent");

   a_digest_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_word |=> !rsp_valid)
      else $error("response continues past the last digest word");

   a_digest_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_word |=>
         rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1)
      else $error("digest word index did not advance");

endmodule
`default_nettype wire
